// File: hdl/pva_pkg.sv
// Shared types, widths and codes for the polyphonic voice allocator.
package pva_pkg;

	localparam int IDX_W   = 4;
	localparam int PITCH_W = 7;
	localparam int CNT_W   = 5;

	typedef logic [1:0] reason_t;
	localparam reason_t REASON_SAME_PITCH = 2'd0;
	localparam reason_t REASON_ROUND_ROBIN = 2'd1;
	localparam reason_t REASON_STEAL = 2'd2;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_UPDATE  = 1'b1;

	// Search token that walks the row of voice cells.
	typedef struct packed {
		logic [PITCH_W-1:0] pitch;
		logic [IDX_W-1:0]   ptr;
		logic [CNT_W-1:0]   active;
		logic               hit_found;
		logic [IDX_W-1:0]   hit_idx;
		logic               hi_found;
		logic [IDX_W-1:0]   hi_idx;
		logic               lo_found;
		logic [IDX_W-1:0]   lo_idx;
	} token_t;

	// Status update broadcast to every cell.
	typedef struct packed {
		logic               wr_en;
		logic [IDX_W-1:0]   idx;
		logic [PITCH_W-1:0] pitch;
		logic               idle;
	} update_t;

	// Voice after v, wrapping at the active count.
	function automatic logic [IDX_W-1:0] next_voice(input logic [IDX_W-1:0] v,
			input logic [CNT_W-1:0] active);
		logic [CNT_W-1:0] s;
		s = {1'b0, v} + CNT_W'(1);
		return (s >= active) ? '0 : s[IDX_W-1:0];
	endfunction

endpackage

// File: hdl/poly_voice_allocator_reuse.sv
// Top level of the polyphonic voice allocator with pitch reuse and round robin.
//
//  channel   | direction | handshake                    | payload
//  s_*       | in        | s_tvalid / s_tready          | s_tdata, s_tuser (kind)
//  m_*       | out       | m_tvalid / m_tready          | m_tdata
//  apb       | in/out    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A request walks the row of MAX_VOICES cells one cell per cycle, the first cell taking
// it at the accepting edge; the decision on the last cell's token is combinational and is
// registered in the fin stage, which hands it to the output register once that is free.
// A status update is written into its cell at the accepting edge and gives no result.
// s_tready is low while a request is inside the row or waits behind the output
// register; a result that waits at the output does not block the next request.
// Reset leaves every voice idle at pitch 0, the pointer at 0 and all voices active.
module poly_voice_allocator_reuse
	import pva_pkg::*;
#(
	parameter int MAX_VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // note_pitch[6:0], voice_index[10:7], voice_is_idle[11]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // chosen_voice[3:0], choice_reason[5:4]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CNT_W-1:0] active_q;
	logic [IDX_W-1:0] ptr_q;
	logic             busy_q;
	logic             fin_valid_q;
	logic [IDX_W-1:0] fin_voice_q;
	reason_t          fin_reason_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_voice_q;
	reason_t          out_reason_q;

	logic             s_accept;
	logic             req_accept;
	logic             cfg_wr;
	logic [CNT_W-1:0] cfg_cnt;
	logic             fin_move;
	update_t          upd;

	logic             tok_v [0:MAX_VOICES];
	token_t           tok   [0:MAX_VOICES];
	token_t           tok_head;

	token_t           last_tok;
	logic [IDX_W-1:0] dec_voice;
	reason_t          dec_reason;
	logic [IDX_W-1:0] dec_ptr;

	assign s_tready   = !busy_q;
	assign s_accept   = s_tvalid && s_tready;
	assign req_accept = s_accept && s_tuser == KIND_REQUEST;
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready && !paddr[2];

	assign upd.wr_en = s_accept && s_tuser == KIND_UPDATE;
	assign upd.idx   = s_tdata[10:7];
	assign upd.pitch = s_tdata[6:0];
	assign upd.idle  = s_tdata[11];

	always_comb begin
		tok_head        = '0;
		tok_head.pitch  = s_tdata[6:0];
		tok_head.ptr    = ptr_q;
		tok_head.active = active_q;
	end

	assign tok[0]   = tok_head;
	assign tok_v[0] = req_accept;

	for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
		pva_cell #(
			.IDX(g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.upd          (upd),
			.tok_valid_in (tok_v[g]),
			.tok_in       (tok[g]),
			.tok_valid_out(tok_v[g+1]),
			.tok_out      (tok[g+1])
		);
	end

	assign last_tok = tok[MAX_VOICES];

	always_comb begin
		if (last_tok.hit_found) begin
			dec_voice  = last_tok.hit_idx;
			dec_reason = REASON_SAME_PITCH;
			dec_ptr    = (last_tok.hit_idx == last_tok.ptr) ?
				next_voice(last_tok.ptr, last_tok.active) : last_tok.ptr;
		end else if (last_tok.hi_found) begin
			dec_voice  = last_tok.hi_idx;
			dec_reason = REASON_ROUND_ROBIN;
			dec_ptr    = next_voice(last_tok.hi_idx, last_tok.active);
		end else if (last_tok.lo_found) begin
			dec_voice  = last_tok.lo_idx;
			dec_reason = REASON_ROUND_ROBIN;
			dec_ptr    = next_voice(last_tok.lo_idx, last_tok.active);
		end else begin
			dec_voice  = last_tok.ptr;
			dec_reason = REASON_STEAL;
			dec_ptr    = next_voice(last_tok.ptr, last_tok.active);
		end
	end

	// A written count of zero means one voice; above the row length it saturates.
	always_comb begin
		cfg_cnt = pwdata[CNT_W-1:0];
		if (cfg_cnt == '0) begin
			cfg_cnt = CNT_W'(1);
		end else if (cfg_cnt > CNT_W'(MAX_VOICES)) begin
			cfg_cnt = CNT_W'(MAX_VOICES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(MAX_VOICES);
			ptr_q    <= '0;
		end else if (cfg_wr) begin
			active_q <= cfg_cnt;
			if ({1'b0, ptr_q} >= cfg_cnt) begin
				ptr_q <= '0;
			end
		end else if (tok_v[MAX_VOICES]) begin
			ptr_q <= dec_ptr;
		end
	end

	assign fin_move = fin_valid_q && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				busy_q <= 1'b1;
			end else if (fin_move) begin
				busy_q <= 1'b0;
			end
			if (tok_v[MAX_VOICES]) begin
				fin_valid_q <= 1'b1;
			end else if (fin_move) begin
				fin_valid_q <= 1'b0;
			end
			if (fin_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_v[MAX_VOICES]) begin
			fin_voice_q  <= dec_voice;
			fin_reason_q <= dec_reason;
		end
		if (fin_move) begin
			out_voice_q  <= fin_voice_q;
			out_reason_q <= fin_reason_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_reason_q, out_voice_q};
	assign prdata   = paddr[2] ? 32'd0 : 32'(active_q);

`ifndef NO_ASSERTIONS
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ptr_q} < active_q)
		else $error("round-robin pointer outside the active voices");

	a_fin_reason: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_q |-> (fin_reason_q == REASON_SAME_PITCH ||
			fin_reason_q == REASON_ROUND_ROBIN || fin_reason_q == REASON_STEAL))
		else $error("decided reason code is undefined");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_v[MAX_VOICES] |-> (busy_q && !fin_valid_q))
		else $error("search token left the row without a request in flight");

	a_req_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> !s_tready)
		else $error("new request taken while a search is running");
`endif

endmodule

// File: hdl/pva_cell.sv
// One voice cell: holds pitch and idle flag and advances the search token.
module pva_cell
	import pva_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  update_t upd,
	input  logic    tok_valid_in,
	input  token_t  tok_in,
	output logic    tok_valid_out,
	output token_t  tok_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [PITCH_W-1:0] pitch_q;
	logic               idle_q;
	logic               tok_valid_q;
	token_t             tok_q;
	token_t             tok_nxt;
	logic               avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			idle_q  <= 1'b1;
		end else if (upd.wr_en && upd.idx == MY_IDX) begin
			pitch_q <= upd.pitch;
			idle_q  <= upd.idle;
		end
	end

	always_comb begin
		avail   = idle_q && ({1'b0, MY_IDX} < tok_in.active);
		tok_nxt = tok_in;
		if (avail && pitch_q == tok_in.pitch && !tok_in.hit_found) begin
			tok_nxt.hit_found = 1'b1;
			tok_nxt.hit_idx   = MY_IDX;
		end
		// Idle voices at or after the pointer win over those before it.
		if (avail && MY_IDX >= tok_in.ptr && !tok_in.hi_found) begin
			tok_nxt.hi_found = 1'b1;
			tok_nxt.hi_idx   = MY_IDX;
		end
		if (avail && MY_IDX < tok_in.ptr && !tok_in.lo_found) begin
			tok_nxt.lo_found = 1'b1;
			tok_nxt.lo_idx   = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign tok_valid_out = tok_valid_q;
	assign tok_out       = tok_q;

endmodule

// File: sim/poly_voice_allocator_reuse_tb.sv
// Self-checking testbench for the polyphonic voice allocator with pitch reuse.
`timescale 1ns / 1ps

localparam int NUM_VOICES = 16;

typedef struct packed {
	logic [pva_pkg::IDX_W-1:0] voice;
	pva_pkg::reason_t          reason;
} voice_choice_t;

// Tracks the voice table, the pointer and the voice count, and holds the
// choices still owed by the block in request order.
class voice_alloc_board;
	logic [pva_pkg::PITCH_W-1:0] pitch_tab [NUM_VOICES];
	bit                          idle_flg [NUM_VOICES];
	int unsigned                 rr_ptr;
	int unsigned                 n_active;
	voice_choice_t               pending [$];
	int                          errors;
	int                          n_req;
	int                          n_upd;
	int                          n_same;
	int                          n_rr;
	int                          n_steal;

	function void clear();
		int i;
		for (i = 0; i < NUM_VOICES; i++) begin
			pitch_tab[i] = '0;
			idle_flg[i] = 1'b1;
		end
		rr_ptr = 0;
		n_active = NUM_VOICES;
	endfunction

	function int unsigned wrap_voice(int unsigned v);
		if (v >= n_active)
			v -= n_active;
		if (v >= n_active)
			v = 0;
		return v;
	endfunction

	function int unsigned step_voice(int unsigned v);
		return wrap_voice(v + 1);
	endfunction

	function void set_count(logic [31:0] value);
		int unsigned n;
		n = value[4:0];
		if (n < 1)
			n = 1;
		if (n > NUM_VOICES)
			n = NUM_VOICES;
		n_active = n;
		if (rr_ptr >= n_active)
			rr_ptr = 0;
	endfunction

	function void note_input(logic kind, logic [6:0] pitch, logic [3:0] vidx, logic idle);
		voice_choice_t c;
		int unsigned   i;
		int unsigned   cand;
		bit            found;
		if (kind == pva_pkg::KIND_UPDATE) begin
			pitch_tab[vidx] = pitch;
			idle_flg[vidx] = idle;
			n_upd++;
			return;
		end
		n_req++;
		if (rr_ptr >= n_active)
			rr_ptr = 0;
		found = 1'b0;
		for (i = 0; i < n_active && !found; i++) begin
			if (idle_flg[i] && pitch_tab[i] == pitch) begin
				found = 1'b1;
				c.voice = 4'(i);
				c.reason = pva_pkg::REASON_SAME_PITCH;
				if (i == rr_ptr)
					rr_ptr = step_voice(rr_ptr);
			end
		end
		for (i = 0; i < n_active && !found; i++) begin
			cand = wrap_voice(i + rr_ptr);
			if (idle_flg[cand]) begin
				found = 1'b1;
				c.voice = 4'(cand);
				c.reason = pva_pkg::REASON_ROUND_ROBIN;
				rr_ptr = step_voice(cand);
			end
		end
		if (!found) begin
			c.voice = 4'(rr_ptr);
			c.reason = pva_pkg::REASON_STEAL;
			rr_ptr = step_voice(rr_ptr);
		end
		unique case (c.reason)
			pva_pkg::REASON_SAME_PITCH: n_same++;
			pva_pkg::REASON_ROUND_ROBIN: n_rr++;
			default: n_steal++;
		endcase
		pending.push_back(c);
	endfunction

	function void check_result(logic [7:0] data);
		voice_choice_t want;
		if (pending.size() == 0) begin
			$error("unexpected result: chosen_voice %0d, choice_reason %0d",
				data[3:0], data[5:4]);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (data[3:0] !== want.voice) begin
			$error("chosen_voice: expected %0d, actual %0d", want.voice, data[3:0]);
			errors++;
		end
		if (data[5:4] !== want.reason) begin
			$error("choice_reason: expected %0d, actual %0d", want.reason, data[5:4]);
			errors++;
		end
	endfunction
endclass

module poly_voice_allocator_reuse_tb;
	import pva_pkg::*;

	localparam logic [2:0] ADDR_ACTIVE_VOICES = 3'd0;
	localparam int         SETTLE_CYCLES = NUM_VOICES + 8;
	localparam int         LONG_HOLD = 400;
	localparam int         LIMIT_CYCLES = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // note_pitch[6:0], voice_index[10:7], voice_is_idle[11]
	logic        s_tuser = 1'b0; // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // chosen_voice[3:0], choice_reason[5:4]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	voice_alloc_board board = new;
	bit          press_on = 1'b0;
	int          n_settings = 0;
	int unsigned cycles = 0;

	poly_voice_allocator_reuse #(.MAX_VOICES(NUM_VOICES)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("** poly_voice_allocator_reuse: FAILED **");
			$finish;
		end
	end

	// Result side: checks every accepted result and stalls in stretches of
	// random mode, with one long hold-off while the pressure phase runs.
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (press_on && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(32, 256);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_item(input logic kind, input logic [6:0] pitch,
			input logic [3:0] vidx, input logic idle);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0000, idle, vidx, pitch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_input(kind, pitch, vidx, idle);
	endtask

	// Stop sending, wait for every owed result, then let the row empty out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_voice_count(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ACTIVE_VOICES;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_count(value);
		n_settings++;
	endtask

	task automatic random_item(input int span, input int idle_pct);
		logic       kind;
		logic [6:0] pitch;
		logic [3:0] vidx;
		logic       idle;
		kind = ($urandom_range(0, 1) == 0) ? KIND_REQUEST : KIND_UPDATE;
		// Pitches cluster on a few notes so that reuse happens often.
		pitch = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, span))
			: 7'($urandom_range(0, 127));
		vidx = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, board.n_active - 1))
			: 4'($urandom_range(0, NUM_VOICES - 1));
		idle = ($urandom_range(0, 99) < idle_pct);
		send_item(kind, pitch, vidx, idle);
	endtask

	task automatic random_phase(input logic [31:0] count_value, input int n_items,
			input int span, input int idle_pct);
		int sent;
		int burst;
		int gap;
		int k;
		drain();
		write_voice_count(count_value);
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < n_items; k++) begin
				random_item(span, idle_pct);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		board.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All voices idle at pitch 0 after reset: reuse at the pointer, round robin, reuse away
		// from the pointer, round robin while the matching voice is busy, then reuse of the lower of two matching voices.
		send_item(KIND_REQUEST, 7'd0, 4'd0, 1'b0);
		send_item(KIND_REQUEST, 7'd127, 4'd15, 1'b1);
		send_item(KIND_UPDATE, 7'd127, 4'd15, 1'b1);
		send_item(KIND_REQUEST, 7'd127, 4'd0, 1'b0);
		send_item(KIND_UPDATE, 7'd5, 4'd3, 1'b0);
		send_item(KIND_REQUEST, 7'd5, 4'd3, 1'b1);
		send_item(KIND_UPDATE, 7'd127, 4'd0, 1'b1);
		send_item(KIND_REQUEST, 7'd127, 4'd0, 1'b0);

		// Two voices, both busy: steals with wrap, and an update beyond the count.
		drain();
		write_voice_count(32'd2);
		send_item(KIND_UPDATE, 7'd10, 4'd0, 1'b0);
		send_item(KIND_UPDATE, 7'd11, 4'd1, 1'b0);
		send_item(KIND_REQUEST, 7'd10, 4'd0, 1'b0);
		send_item(KIND_REQUEST, 7'd10, 4'd0, 1'b0);
		send_item(KIND_UPDATE, 7'd9, 4'd14, 1'b1);
		send_item(KIND_REQUEST, 7'd9, 4'd14, 1'b0);

		// A count of zero behaves as one voice.
		drain();
		write_voice_count(32'd0);
		send_item(KIND_REQUEST, 7'd11, 4'd0, 1'b0);
		send_item(KIND_UPDATE, 7'd11, 4'd0, 1'b1);
		send_item(KIND_REQUEST, 7'd11, 4'd0, 1'b0);

		// A count above the maximum behaves as all voices; the stored update shows up.
		drain();
		write_voice_count(32'd31);
		send_item(KIND_REQUEST, 7'd9, 4'd0, 1'b0);
		send_item(KIND_UPDATE, 7'd127, 4'd7, 1'b0);
		send_item(KIND_UPDATE, 7'd0, 4'd15, 1'b0);
		send_item(KIND_REQUEST, 7'd0, 4'd15, 1'b1);

		random_phase(32'd16, 150, 7, 50);
		random_phase(32'd1, 60, 3, 50);
		// Empty the block first so that the long hold-off overlaps the sending.
		drain();
		write_voice_count(32'd4);
		press_on = 1'b1;
		random_phase(32'd4, 120, 3, 30);
		press_on = 1'b0;
		random_phase(32'd31, 150, 15, 10);
		random_phase(32'd0, 40, 3, 50);
		random_phase($urandom_range(2, 15), 150, 7, 40);
		random_phase(32'h0000_0103, 80, 127, 50);
		random_phase(32'd16, 150, 5, 20);

		drain();
		$display("Run covered %0d note requests and %0d status updates with %0d count writes.",
			board.n_req, board.n_upd, n_settings);
		$display("Choices seen: %0d same-pitch reuses, %0d round-robin picks, %0d steals.",
			board.n_same, board.n_rr, board.n_steal);
		if (board.errors == 0) begin
			$display("** poly_voice_allocator_reuse: PASSED **");
		end else begin
			$display("** poly_voice_allocator_reuse: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/pva_pkg.sv
hdl/pva_cell.sv
hdl/poly_voice_allocator_reuse.sv
sim/poly_voice_allocator_reuse_tb.sv
